// ----- hdl/dmacr_pkg.sv -----
// ---------------------------------------------------------------------------
// dmacr_pkg: shared constants and helpers for the DMA controller registers
// Register map codes, bit positions, write masks and unit-size decode.
// ---------------------------------------------------------------------------
`default_nettype none

package dmacr_pkg;

	// Access kinds
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Register map
	localparam logic [7:0] OFF_DMAOR = 8'h40;
	localparam logic [3:0] REG_SAR   = 4'h0;
	localparam logic [3:0] REG_DAR   = 4'h4;
	localparam logic [3:0] REG_TCR   = 4'h8;

	// CHCR bits
	localparam int BIT_DE = 0;
	localparam int BIT_TE = 1;
	localparam int BIT_IE = 2;
	// DMAOR bits
	localparam int BIT_DME = 0;

	localparam logic [3:0]  RS_AUTO    = 4'd4;
	localparam logic [1:0]  MODE_INC   = 2'd1;
	localparam logic [1:0]  MODE_DEC   = 2'd2;

	localparam logic [31:0] OR_MASK    = 32'hFFFF_8201;
	localparam logic [31:0] OR_FLAGS   = 32'h0000_0006;
	localparam logic [31:0] TCR_MASK   = 32'h00FF_FFFF;
	localparam logic [31:0] CC_MASK_LO = 32'hFF0F_FFF7;
	localparam logic [31:0] CC_MASK_HI = 32'hFF0A_FFF7;
	localparam logic [24:0] FULL_COUNT = 25'h100_0000;

	// Launch details handed from the launch unit to the top level
	typedef struct packed {
		logic               ok;
		logic [5:0]         unit_bytes;
		logic [24:0]        count;
		logic signed [6:0]  source_step;
		logic signed [6:0]  dest_step;
		logic [31:0]        sar_next;
		logic [31:0]        dar_next;
	} launch_t;

	// Bytes per unit for a TS code; zero marks an unused code
	function automatic logic [5:0] unit_bytes(input logic [2:0] ts);
		logic [5:0] u;
		case (ts)
			3'd0:    u = 6'd8;
			3'd1:    u = 6'd1;
			3'd2:    u = 6'd2;
			3'd3:    u = 6'd4;
			3'd4:    u = 6'd32;
			default: u = 6'd0;
		endcase
		return u;
	endfunction

	// log2 of the unit size, used to scale the count without a multiplier
	function automatic logic [2:0] unit_shift(input logic [2:0] ts);
		logic [2:0] s;
		case (ts)
			3'd0:    s = 3'd3;
			3'd1:    s = 3'd0;
			3'd2:    s = 3'd1;
			3'd3:    s = 3'd2;
			3'd4:    s = 3'd5;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/dmacr_launch.sv -----
// ---------------------------------------------------------------------------
// dmacr_launch: transfer launch decode
// Derives unit size, count, signed steps and final addresses of a channel.
// ---------------------------------------------------------------------------
`default_nettype none

module dmacr_launch import dmacr_pkg::*; (
	input  wire logic [31:0] chcr,
	input  wire logic [31:0] sar,
	input  wire logic [31:0] dar,
	input  wire logic [23:0] tcr,
	output launch_t          info
);

	logic [2:0]  ts;
	logic [5:0]  unit;
	logic [2:0]  sh;
	logic [24:0] cnt;
	logic [31:0] delta;
	logic signed [6:0] pos_step;

	always_comb begin
		ts    = chcr[6:4];
		unit  = unit_bytes(ts);
		sh    = unit_shift(ts);
		cnt   = (tcr == 24'd0) ? FULL_COUNT : {1'b0, tcr};
		// count * unit fits in 30 bits; wrap to 32 like the address registers
		delta = {7'd0, cnt} << sh;
		pos_step = signed'({1'b0, unit});

		info.ok         = (unit != 6'd0);
		info.unit_bytes = unit;
		info.count      = cnt;

		case (chcr[13:12])
			MODE_INC: begin
				info.source_step = pos_step;
				info.sar_next    = sar + delta;
			end
			MODE_DEC: begin
				info.source_step = -pos_step;
				info.sar_next    = sar - delta;
			end
			default: begin
				info.source_step = 7'sd0;
				info.sar_next    = sar;
			end
		endcase

		case (chcr[15:14])
			MODE_INC: begin
				info.dest_step = pos_step;
				info.dar_next  = dar + delta;
			end
			MODE_DEC: begin
				info.dest_step = -pos_step;
				info.dar_next  = dar - delta;
			end
			default: begin
				info.dest_step = 7'sd0;
				info.dar_next  = dar;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/dma_controller_registers.sv -----
// An accepted access word loads the input register, and its result word loads
// the result register when that register is free or being drained.
// Throughput: one access per cycle while m_tready holds; state updates land at
// the same edge that loads the result, so the next access already sees them.
// Reset: arst_n clears all channel registers and DMAOR to zero at once.
// ---------------------------------------------------------------------------
// dma_controller_registers: four-channel DMA controller register block
// Bus reads and writes of SAR/DAR/TCR/CHCR per channel and the shared DMAOR.
// An auto-request CHCR write reports the transfer for an external mover and
// completes the channel registers immediately.
// ---------------------------------------------------------------------------
`default_nettype none

module dma_controller_registers import dmacr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// access word
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,   // offset[7:0], write_data[39:8]
	input  wire logic         s_tuser,   // cmd (0 read, 1 write)
	// result word
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// read_data[31:0], copy_channel[33:32], copy_source[65:34],
	// copy_dest[97:66], copy_unit_bytes[103:98], copy_count[128:104],
	// source_step[135:129], dest_step[142:136], irq[143]
	output logic [143:0]      m_tdata,
	output logic              m_tuser    // copy_started
);

	// ---------------- architectural registers ----------------
	logic [31:0] sar_q  [4];
	logic [31:0] dar_q  [4];
	logic [23:0] tcr_q  [4];
	logic [31:0] chcr_q [4];
	logic [31:0] dmaor_q;

	// ---------------- input register ----------------
	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  off_s1;
	logic [31:0] wdata_s1;

	// ---------------- result register ----------------
	logic        out_valid_q;
	logic [31:0] rdata_q;
	logic        started_q;
	logic [1:0]  chan_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [5:0]  unit_q;
	logic [24:0] count_q;
	logic [6:0]  sstep_q;
	logic [6:0]  dstep_q;
	logic        irq_q;

	logic        advance;
	logic [1:0]  ch;
	logic [3:0]  reg_sel;
	logic        mapped;
	logic        is_or;
	logic        is_wr;
	logic        is_chcr;
	logic [31:0] rd_val;
	logic [31:0] chcr_new;
	logic        go;
	launch_t     info;

	// Move the access forward when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			off_s1   <= s_tdata[7:0];
			wdata_s1 <= s_tdata[39:8];
		end
	end

	// ---------------- decode ----------------
	always_comb begin
		ch      = off_s1[5:4];
		reg_sel = off_s1[3:0];
		mapped  = (off_s1 < OFF_DMAOR);
		is_or   = (off_s1 == OFF_DMAOR);
		is_wr   = (cmd_s1 == CMD_WRITE);
		is_chcr = (reg_sel != REG_SAR) && (reg_sel != REG_DAR) && (reg_sel != REG_TCR);

		// read mux: offsets above DMAOR read zero
		rd_val = 32'd0;
		if (is_or) begin
			rd_val = dmaor_q;
		end else if (mapped) begin
			case (reg_sel)
				REG_SAR: rd_val = sar_q[ch];
				REG_DAR: rd_val = dar_q[ch];
				REG_TCR: rd_val = {8'd0, tcr_q[ch]};
				default: rd_val = chcr_q[ch];
			endcase
		end

		// TE can only be held by writing 1, never set by a write
		chcr_new = (wdata_s1 & (ch[1] ? CC_MASK_HI : CC_MASK_LO) & ~(32'd1 << BIT_TE))
		         | (chcr_q[ch] & wdata_s1 & (32'd1 << BIT_TE));

		// auto-request launch; reserved unit codes drop the launch quietly
		go = is_wr && mapped && is_chcr && !chcr_new[BIT_TE] && chcr_new[BIT_DE]
		   && dmaor_q[BIT_DME] && (chcr_new[11:8] == RS_AUTO) && info.ok;
	end

	dmacr_launch u_launch (
		.chcr (chcr_new),
		.sar  (sar_q[ch]),
		.dar  (dar_q[ch]),
		.tcr  (tcr_q[ch]),
		.info (info)
	);

	// ---------------- register updates ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				sar_q[i]  <= 32'd0;
				dar_q[i]  <= 32'd0;
				tcr_q[i]  <= 24'd0;
				chcr_q[i] <= 32'd0;
			end
			dmaor_q <= 32'd0;
		end else if (advance && is_wr) begin
			if (is_or) begin
				// NMIF and AE: clear on write-zero, hold on write-one
				dmaor_q <= (wdata_s1 & OR_MASK) | (dmaor_q & wdata_s1 & OR_FLAGS);
			end else if (mapped) begin
				case (reg_sel)
					REG_SAR: sar_q[ch] <= wdata_s1;
					REG_DAR: dar_q[ch] <= wdata_s1;
					REG_TCR: tcr_q[ch] <= wdata_s1[23:0];
					default: begin
						if (go) begin
							// complete the transfer at once
							chcr_q[ch] <= chcr_new | (32'd1 << BIT_TE);
							sar_q[ch]  <= info.sar_next;
							dar_q[ch]  <= info.dar_next;
							tcr_q[ch]  <= 24'd0;
						end else begin
							chcr_q[ch] <= chcr_new;
						end
					end
				endcase
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q   <= is_wr ? 32'd0 : rd_val;
			started_q <= go;
			chan_q    <= go ? ch : 2'd0;
			src_q     <= go ? sar_q[ch] : 32'd0;
			dst_q     <= go ? dar_q[ch] : 32'd0;
			unit_q    <= go ? info.unit_bytes : 6'd0;
			count_q   <= go ? info.count : 25'd0;
			sstep_q   <= go ? info.source_step : 7'd0;
			dstep_q   <= go ? info.dest_step : 7'd0;
			irq_q     <= go && chcr_new[BIT_IE];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = started_q;
	assign m_tdata  = {irq_q, dstep_q, sstep_q, count_q, unit_q, dst_q, src_q, chan_q, rdata_q};

	// ---------------- assertions ----------------
	// a launch always reports a real unit size
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[103:98] != 6'd0)
		else $error("launch reported with zero unit size");

	// without a launch every copy field reads zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[143:32] == 112'd0)
		else $error("copy fields set without a launch");

	// a launched channel ends with TE set and TCR cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && go |=> chcr_q[$past(ch)][BIT_TE] && tcr_q[$past(ch)] == 24'd0)
		else $error("launched channel not completed");

	// a stalled access stays in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(off_s1) && $stable(cmd_s1))
		else $error("stalled access lost");

endmodule

`default_nettype wire
